@@ rtl/cci_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cci_pkg
// Shared widths, status codes and the geometry payload for the circle-circle
// intersection pipeline.
// ----------------------------------------------------------------------------
package cci_pkg;

   // coordinate width of every input and output field
   localparam int CW    = 16;
   // center difference and center sum
   localparam int DW    = CW + 1;
   // squared center distance
   localparam int D2W   = 2 * CW + 1;
   // difference of squared radii
   localparam int EW    = 2 * CW;
   // squared radius sum, also width of P
   localparam int SQW   = 2 * CW + 2;
   // low slice of Q used by the split product
   localparam int QLOW  = CW + 1;
   // radicand width (P*Q), kept even
   localparam int PQW   = 4 * CW + 4;
   // square root width
   localparam int RTW   = PQW / 2;
   // square root partial remainder
   localparam int SRW   = RTW + 2;
   // numerator accumulator
   localparam int ACCW  = 3 * CW + 6;
   // denominator 2*d2
   localparam int DENW  = D2W + 1;
   // divider remainder
   localparam int REMW  = DENW + CW;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_NONE = 2'd1,
      STATUS_SAT  = 2'd2
   } status_type;

   // geometry that travels alongside the square root
   typedef struct packed {
      logic signed [DW-1:0] sum_x;
      logic signed [DW-1:0] sum_y;
      logic signed [DW-1:0] d_x;
      logic signed [DW-1:0] d_y;
      logic [D2W-1:0]       dist2;
      logic [EW-1:0]        ediff;
      logic                 eneg;
      logic                 pick;
      logic                 nosol;
   } geo_type;

endpackage

@@ rtl/cci_prep.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cci_prep
// Front end: differences, squares, solvability test and the product P*Q,
// six register stages.
// ----------------------------------------------------------------------------
module cci_prep import cci_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_vld,
   input  logic signed [CW-1:0] ax,
   input  logic signed [CW-1:0] ay,
   input  logic signed [CW-1:0] bx,
   input  logic signed [CW-1:0] by,
   input  logic [CW-1:0]        ra,
   input  logic [CW-1:0]        rb,
   input  logic                 pick,
   output logic                 out_vld,
   output geo_type              out_geo,
   output logic [PQW-1:0]       out_pq
);

   // stage 1 registers
   logic                 vld1_ff;
   logic [DW-1:0]        dx1_ff, dy1_ff, sx1_ff, sy1_ff, dx1_in, dy1_in, sx1_in, sy1_in;
   logic [DW-1:0]        rs1_ff, rs1_in;
   logic [CW-1:0]        rd1_ff, rd1_in, ra1_ff, rb1_ff;
   logic                 eneg1_ff, pick1_ff;
   // stage 2 registers
   logic                 vld2_ff;
   logic [DW-1:0]        dx2_ff, dy2_ff, sx2_ff, sy2_ff;
   logic [CW-1:0]        adx, ady;
   logic [EW-1:0]        xx2_ff, yy2_ff, tt2_ff, aa2_ff, bb2_ff;
   logic [SQW-1:0]       sq2_ff;
   logic                 eneg2_ff, pick2_ff;
   // stage 3 registers
   logic                 vld3_ff;
   logic [DW-1:0]        dx3_ff, dy3_ff, sx3_ff, sy3_ff;
   logic [D2W-1:0]       d3_ff, d3_in;
   logic [EW-1:0]        e3_ff, e3_in, tt3_ff;
   logic [SQW-1:0]       sq3_ff;
   logic                 eneg3_ff, pick3_ff;
   // stage 4..6 registers
   logic                 vld4_ff, vld5_ff, vld6_ff;
   geo_type              geo4_ff, geo4_in, geo5_ff, geo6_ff;
   logic [SQW-1:0]       p4_ff, p4_in;
   logic [D2W-1:0]       q4_ff, q4_in;
   logic [SQW+QLOW-1:0]  plo5_ff;
   logic [SQW+D2W-QLOW-1:0] phi5_ff;
   logic [PQW-1:0]       pq6_ff, pq6_in;

   // differences, sums and radius combinations
   assign dx1_in = {bx[CW-1], bx} - {ax[CW-1], ax};
   assign dy1_in = {by[CW-1], by} - {ay[CW-1], ay};
   assign sx1_in = {bx[CW-1], bx} + {ax[CW-1], ax};
   assign sy1_in = {by[CW-1], by} + {ay[CW-1], ay};
   assign rs1_in = {1'b0, ra} + {1'b0, rb};
   assign rd1_in = (ra >= rb) ? (ra - rb) : (rb - ra);

   // magnitudes for squaring
   assign adx = dx1_ff[DW-1] ? CW'(-dx1_ff) : dx1_ff[CW-1:0];
   assign ady = dy1_ff[DW-1] ? CW'(-dy1_ff) : dy1_ff[CW-1:0];

   // distance and radius square difference
   assign d3_in = D2W'(xx2_ff) + D2W'(yy2_ff);
   assign e3_in = eneg2_ff ? (bb2_ff - aa2_ff) : (aa2_ff - bb2_ff);

   // solvability test and P, Q
   always_comb begin
      geo4_in.sum_x = sx3_ff;
      geo4_in.sum_y = sy3_ff;
      geo4_in.d_x   = dx3_ff;
      geo4_in.d_y   = dy3_ff;
      geo4_in.dist2 = d3_ff;
      geo4_in.ediff = e3_ff;
      geo4_in.eneg  = eneg3_ff;
      geo4_in.pick  = pick3_ff;
      geo4_in.nosol = (d3_ff == '0) || (sq3_ff < SQW'(d3_ff)) || (d3_ff < D2W'(tt3_ff));
      p4_in         = sq3_ff - SQW'(d3_ff);
      q4_in         = d3_ff - D2W'(tt3_ff);
   end

   // recombine the split product
   assign pq6_in = PQW'(plo5_ff) + (PQW'(phi5_ff) << QLOW);

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
         vld5_ff <= 1'b0;
         vld6_ff <= 1'b0;
      end else if (en) begin
         vld1_ff <= in_vld;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
         vld4_ff <= vld3_ff;
         vld5_ff <= vld4_ff;
         vld6_ff <= vld5_ff;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (en) begin
         dx1_ff   <= dx1_in;
         dy1_ff   <= dy1_in;
         sx1_ff   <= sx1_in;
         sy1_ff   <= sy1_in;
         rs1_ff   <= rs1_in;
         rd1_ff   <= rd1_in;
         ra1_ff   <= ra;
         rb1_ff   <= rb;
         eneg1_ff <= (ra < rb);
         pick1_ff <= pick;

         dx2_ff   <= dx1_ff;
         dy2_ff   <= dy1_ff;
         sx2_ff   <= sx1_ff;
         sy2_ff   <= sy1_ff;
         xx2_ff   <= adx * adx;
         yy2_ff   <= ady * ady;
         sq2_ff   <= rs1_ff * rs1_ff;
         tt2_ff   <= rd1_ff * rd1_ff;
         aa2_ff   <= ra1_ff * ra1_ff;
         bb2_ff   <= rb1_ff * rb1_ff;
         eneg2_ff <= eneg1_ff;
         pick2_ff <= pick1_ff;

         dx3_ff   <= dx2_ff;
         dy3_ff   <= dy2_ff;
         sx3_ff   <= sx2_ff;
         sy3_ff   <= sy2_ff;
         d3_ff    <= d3_in;
         e3_ff    <= e3_in;
         tt3_ff   <= tt2_ff;
         sq3_ff   <= sq2_ff;
         eneg3_ff <= eneg2_ff;
         pick3_ff <= pick2_ff;

         geo4_ff  <= geo4_in;
         p4_ff    <= p4_in;
         q4_ff    <= q4_in;

         geo5_ff  <= geo4_ff;
         plo5_ff  <= p4_ff * q4_ff[QLOW-1:0];
         phi5_ff  <= p4_ff * q4_ff[D2W-1:QLOW];

         geo6_ff  <= geo5_ff;
         pq6_ff   <= pq6_in;
      end
   end

   assign out_vld = vld6_ff;
   assign out_geo = geo6_ff;
   assign out_pq  = pq6_ff;

endmodule

@@ rtl/cci_sqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cci_sqrt
// Pipelined integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module cci_sqrt import cci_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  logic           in_vld,
   input  geo_type        in_geo,
   input  logic [PQW-1:0] in_pq,
   output logic           out_vld,
   output geo_type        out_geo,
   output logic [RTW-1:0] out_root
);

   logic           vld_ff  [RTW];
   geo_type        geo_ff  [RTW];
   logic [SRW-1:0] rem_ff  [RTW];
   logic [RTW-1:0] root_ff [RTW];
   logic [PQW-1:0] rad_ff  [RTW];

   for (genvar i = 0; i < RTW; i++) begin : g_step
      logic           vld_src;
      geo_type        geo_src;
      logic [SRW-1:0] rem_src, rem_sh, trial;
      logic [RTW-1:0] root_src;
      logic [PQW-1:0] rad_src;
      logic           take;

      if (i == 0) begin : g_first
         assign vld_src  = in_vld;
         assign geo_src  = in_geo;
         assign rem_src  = '0;
         assign root_src = '0;
         assign rad_src  = in_pq;
      end else begin : g_next
         assign vld_src  = vld_ff[i-1];
         assign geo_src  = geo_ff[i-1];
         assign rem_src  = rem_ff[i-1];
         assign root_src = root_ff[i-1];
         assign rad_src  = rad_ff[i-1];
      end

      // bring down two radicand bits and try the next root bit
      assign rem_sh = {rem_src[SRW-3:0], rad_src[PQW-1 -: 2]};
      assign trial  = {root_src, 2'b01};
      assign take   = (rem_sh >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en) begin
            vld_ff[i] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            geo_ff[i]  <= geo_src;
            rem_ff[i]  <= take ? (rem_sh - trial) : rem_sh;
            root_ff[i] <= {root_src[RTW-2:0], take};
            rad_ff[i]  <= rad_src << 2;
         end
      end
   end

   assign out_vld  = vld_ff[RTW-1];
   assign out_geo  = geo_ff[RTW-1];
   assign out_root = root_ff[RTW-1];

endmodule

@@ rtl/cci_axis.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cci_axis
// One output coordinate: builds the exact numerator over 2*d2, rounds it with
// a pipelined restoring divider and saturates to the coordinate range.
// ----------------------------------------------------------------------------
module cci_axis import cci_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_vld,
   input  logic signed [DW-1:0] sum,
   input  logic signed [DW-1:0] dpar,
   input  logic signed [DW-1:0] dperp,
   input  logic [D2W-1:0]       dist2,
   input  logic [EW-1:0]        ediff,
   input  logic                 eneg,
   input  logic                 minus,
   input  logic                 nosol,
   input  logic [RTW-1:0]       root,
   output logic                 out_vld,
   output logic signed [CW-1:0] point,
   output logic                 sat,
   output logic                 out_nosol
);

   localparam int P1W = DW + D2W + 1;
   localparam int P2W = DW + EW + 1;
   localparam int P3W = DW + RTW + 1;

   // numerator stages
   logic                  vld1_ff, vld2_ff, vld3_ff;
   logic signed [P1W-1:0] p1_ff, p1_in;
   logic signed [P2W-1:0] p2_ff, p2_in;
   logic signed [P3W-1:0] p3_ff, p3_in;
   logic [D2W-1:0]        d1_ff, d2_ff, d3_ff;
   logic                  eneg1_ff, minus1_ff, ns1_ff, ns2_ff, ns3_ff;
   logic [ACCW-1:0]       acc2_ff, acc2_in, mag3_ff, mag3_in;
   logic                  neg3_ff;
   logic [DENW-1:0]       den2;

   // divider stages
   logic                  vld_ff  [CW];
   logic [REMW-1:0]       rem_ff  [CW];
   logic [CW-1:0]         q_ff    [CW];
   logic [DENW-1:0]       den_ff  [CW];
   logic                  neg_ff  [CW];
   logic                  ovf_ff  [CW];
   logic                  ns_ff   [CW];

   // output stage
   logic                  vldo_ff, sato_ff, nso_ff, sat_in;
   logic [CW-1:0]         pto_ff, pt_in, qf;

   // three signed products
   assign p1_in = sum * $signed({1'b0, dist2});
   assign p2_in = dpar * $signed({1'b0, ediff});
   assign p3_in = dperp * $signed({1'b0, root});

   // exact numerator with the rounding half added
   assign acc2_in = ACCW'(p1_ff)
                  + (eneg1_ff ? -ACCW'(p2_ff) : ACCW'(p2_ff))
                  + (minus1_ff ? -ACCW'(p3_ff) : ACCW'(p3_ff))
                  + ACCW'(d1_ff);

   // floor magnitude: negative values take 2*d2 - 1 more before dividing
   assign den2    = {d2_ff, 1'b0};
   assign mag3_in = acc2_ff[ACCW-1] ? (~acc2_ff + ACCW'(den2)) : acc2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
      end else if (en) begin
         vld1_ff <= in_vld;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff     <= p1_in;
         p2_ff     <= p2_in;
         p3_ff     <= p3_in;
         d1_ff     <= dist2;
         eneg1_ff  <= eneg;
         minus1_ff <= minus;
         ns1_ff    <= nosol;

         acc2_ff   <= acc2_in;
         d2_ff     <= d1_ff;
         ns2_ff    <= ns1_ff;

         mag3_ff   <= mag3_in;
         neg3_ff   <= acc2_ff[ACCW-1];
         d3_ff     <= d2_ff;
         ns3_ff    <= ns2_ff;
      end
   end

   // restoring divider, one quotient bit per stage, msb first
   for (genvar i = 0; i < CW; i++) begin : g_div
      logic            vld_src, neg_src, ovf_src, ns_src, take;
      logic [REMW-1:0] rem_src, shd;
      logic [CW-1:0]   q_src;
      logic [DENW-1:0] den_src;

      if (i == 0) begin : g_first
         assign vld_src = vld3_ff;
         assign neg_src = neg3_ff;
         assign ns_src  = ns3_ff;
         assign den_src = {d3_ff, 1'b0};
         assign rem_src = mag3_ff[REMW-1:0];
         assign q_src   = '0;
         // quotient would need more than CW bits
         assign ovf_src = (mag3_ff >= ACCW'({den_src, CW'(0)}));
      end else begin : g_next
         assign vld_src = vld_ff[i-1];
         assign neg_src = neg_ff[i-1];
         assign ns_src  = ns_ff[i-1];
         assign den_src = den_ff[i-1];
         assign rem_src = rem_ff[i-1];
         assign q_src   = q_ff[i-1];
         assign ovf_src = ovf_ff[i-1];
      end

      assign shd  = REMW'(den_src) << (CW - 1 - i);
      assign take = (rem_src >= shd);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en) begin
            vld_ff[i] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= take ? (rem_src - shd) : rem_src;
            q_ff[i]   <= q_src | (CW'(take) << (CW - 1 - i));
            den_ff[i] <= den_src;
            neg_ff[i] <= neg_src;
            ovf_ff[i] <= ovf_src;
            ns_ff[i]  <= ns_src;
         end
      end
   end

   // sign and saturation
   assign qf = q_ff[CW-1];
   always_comb begin
      if (neg_ff[CW-1]) begin
         sat_in = ovf_ff[CW-1] || (qf > (CW'(1) << (CW - 1)));
         pt_in  = sat_in ? (CW'(1) << (CW - 1)) : (-qf);
      end else begin
         sat_in = ovf_ff[CW-1] || qf[CW-1];
         pt_in  = sat_in ? ~(CW'(1) << (CW - 1)) : qf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vldo_ff <= 1'b0;
      end else if (en) begin
         vldo_ff <= vld_ff[CW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pto_ff  <= pt_in;
         sato_ff <= sat_in;
         nso_ff  <= ns_ff[CW-1];
      end
   end

   assign out_vld   = vldo_ff;
   assign point     = $signed(pto_ff);
   assign sat       = sato_ff;
   assign out_nosol = nso_ff;

endmodule

@@ rtl/circle_circle_intersection_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_circle_intersection_top
// Returns one intersection point of two circles given in signed Q8.8.
//
//   channel   ports                        direction
//   req       req_valid / req_stall        query in, seven fields
//   rsp       rsp_valid / rsp_stall        point and status out
//
// One query can enter every clock while req_stall is low; the path is 6 front-end
// stages, 34 square root stages, 20 numerator, divider and saturation stages and
// 1 output register.
// The square root of the 68-bit radicand, one root bit per stage, sets the depth.
// Synchronous reset clears only the valid bits.
// While rsp_stall holds a waiting result the whole pipeline freezes and
// req_stall is raised; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module circle_circle_intersection_top import cci_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic signed [CW-1:0] req_center_a_x,
   input  logic signed [CW-1:0] req_center_a_y,
   input  logic signed [CW-1:0] req_center_b_x,
   input  logic signed [CW-1:0] req_center_b_y,
   input  logic [CW-1:0]        req_radius_a,
   input  logic [CW-1:0]        req_radius_b,
   input  logic                 req_pick_first,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [CW-1:0] rsp_point_x,
   output logic signed [CW-1:0] rsp_point_y,
   output logic [1:0]           rsp_status
);

   logic                 adv;
   logic                 prep_vld, sq_vld, ax_vld, ay_vld;
   geo_type              prep_geo, sq_geo;
   logic [PQW-1:0]       prep_pq;
   logic [RTW-1:0]       sq_root;
   logic signed [CW-1:0] px, py;
   logic                 sx, sy, nx, ny;

   logic                 rsp_valid_ff;
   logic [CW-1:0]        x_ff, y_ff, x_in, y_in;
   status_type           st_ff, st_in;

   // pipeline moves whenever the output register is free or being taken
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   cci_prep u_prep (
      .clock   (clock),
      .reset   (reset),
      .en      (adv),
      .in_vld  (req_valid),
      .ax      (req_center_a_x),
      .ay      (req_center_a_y),
      .bx      (req_center_b_x),
      .by      (req_center_b_y),
      .ra      (req_radius_a),
      .rb      (req_radius_b),
      .pick    (req_pick_first),
      .out_vld (prep_vld),
      .out_geo (prep_geo),
      .out_pq  (prep_pq)
   );

   cci_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_vld   (prep_vld),
      .in_geo   (prep_geo),
      .in_pq    (prep_pq),
      .out_vld  (sq_vld),
      .out_geo  (sq_geo),
      .out_root (sq_root)
   );

   // x uses the minus offset when pick is set, y the plus offset
   cci_axis u_axis_x (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_vld    (sq_vld),
      .sum       (sq_geo.sum_x),
      .dpar      (sq_geo.d_x),
      .dperp     (sq_geo.d_y),
      .dist2     (sq_geo.dist2),
      .ediff     (sq_geo.ediff),
      .eneg      (sq_geo.eneg),
      .minus     (sq_geo.pick),
      .nosol     (sq_geo.nosol),
      .root      (sq_root),
      .out_vld   (ax_vld),
      .point     (px),
      .sat       (sx),
      .out_nosol (nx)
   );

   cci_axis u_axis_y (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_vld    (sq_vld),
      .sum       (sq_geo.sum_y),
      .dpar      (sq_geo.d_y),
      .dperp     (sq_geo.d_x),
      .dist2     (sq_geo.dist2),
      .ediff     (sq_geo.ediff),
      .eneg      (sq_geo.eneg),
      .minus     (!sq_geo.pick),
      .nosol     (sq_geo.nosol),
      .root      (sq_root),
      .out_vld   (ay_vld),
      .point     (py),
      .sat       (sy),
      .out_nosol (ny)
   );

   // status and point selection
   always_comb begin
      if (nx || ny) begin
         st_in = STATUS_NONE;
         x_in  = '0;
         y_in  = '0;
      end else begin
         st_in = (sx || sy) ? STATUS_SAT : STATUS_OK;
         x_in  = px;
         y_in  = py;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= ax_vld && ay_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff  <= x_in;
         y_ff  <= y_in;
         st_ff <= st_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_point_x = $signed(x_ff);
   assign rsp_point_y = $signed(y_ff);
   assign rsp_status  = st_ff;

endmodule
